// ===== hdl/coalescing_error_event_log_defines.svh =====
// Assertion macros used by the checker file of the error event log.
// No dependencies; include by bare file name.
`ifndef COALESCING_ERROR_EVENT_LOG_DEFINES_SVH
`define COALESCING_ERROR_EVENT_LOG_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define CEEL_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define CEEL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/ceel_pkg.sv =====
// Shared types, widths and codes of the coalescing error event log.
// No dependencies; used by the interfaces, every module and the checker.
package ceel_pkg;

	localparam int HISTORY_DEPTH_DEF = 16;

	localparam int MODE_W     = 2;
	localparam int SOURCE_W   = 4;
	localparam int CODE_W     = 16;
	localparam int SEVERITY_W = 2;
	localparam int TIME_W     = 32;
	localparam int RIDX_W     = 4;
	localparam int ACTION_W   = 3;
	localparam int RPT_W      = 16;
	localparam int ENTRIES_W  = 5;
	localparam int TOTAL_W    = 32;

	localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd100;
	localparam logic [RPT_W-1:0]  REPEAT_MAX   = 16'hFFFF;

	typedef enum logic [MODE_W-1:0] {
		MODE_REPORT = 2'd0,
		MODE_CLEAR  = 2'd1,
		MODE_READ   = 2'd2,
		MODE_UNUSED = 2'd3
	} mode_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_IGNORED   = 3'd0,
		ACT_NEW       = 3'd1,
		ACT_COALESCED = 3'd2,
		ACT_CLEARED   = 3'd3,
		ACT_READ      = 3'd4
	} action_t;

	// Identity of an event; source sits in the top bits.
	typedef struct packed {
		logic [SOURCE_W-1:0]   source;
		logic [CODE_W-1:0]     code;
		logic [SEVERITY_W-1:0] severity;
	} hist_tag_t;

	// One history entry as it is stored in memory.
	typedef struct packed {
		hist_tag_t           tag;
		logic [TIME_W-1:0]   stamp;
		logic [RPT_W-1:0]    rpt;
	} hist_entry_t;

endpackage

// ===== hdl/ceel_in_if.sv =====
// Input channel of the error event log: one event, clear or read request per word.
// Depends on ceel_pkg for field widths.
interface ceel_in_if;
	logic                                valid;
	logic                                ready;
	logic [ceel_pkg::MODE_W-1:0]         mode;
	logic [ceel_pkg::SOURCE_W-1:0]       source;
	logic [ceel_pkg::CODE_W-1:0]         code;
	logic [ceel_pkg::SEVERITY_W-1:0]     severity;
	logic [ceel_pkg::TIME_W-1:0]         event_time;
	logic [ceel_pkg::RIDX_W-1:0]         read_index;

	modport source_mp (output valid, mode, source, code, severity, event_time, read_index,
		input ready);
	modport sink (input valid, mode, source, code, severity, event_time, read_index,
		output ready);
endinterface

// ===== hdl/ceel_out_if.sv =====
// Result channel of the error event log: one record word per accepted input word.
// Depends on ceel_pkg for field widths.
interface ceel_out_if;
	logic                                valid;
	logic                                ready;
	logic [ceel_pkg::ACTION_W-1:0]       action;
	logic                                rec_valid;
	logic [ceel_pkg::SOURCE_W-1:0]       rec_source;
	logic [ceel_pkg::CODE_W-1:0]         rec_code;
	logic [ceel_pkg::SEVERITY_W-1:0]     rec_severity;
	logic [ceel_pkg::TIME_W-1:0]         rec_time;
	logic [ceel_pkg::RPT_W-1:0]          rec_repeat;
	logic [ceel_pkg::ENTRIES_W-1:0]      stored_entries;
	logic [ceel_pkg::TOTAL_W-1:0]        total_reports;

	modport source (output valid, action, rec_valid, rec_source, rec_code, rec_severity,
		rec_time, rec_repeat, stored_entries, total_reports, input ready);
	modport sink (input valid, action, rec_valid, rec_source, rec_code, rec_severity,
		rec_time, rec_repeat, stored_entries, total_reports, output ready);
endinterface

// ===== hdl/ceel_cfg_if.sv =====
// Configuration write channel carrying the coalescing window in ms.
// Depends on ceel_pkg for the data width.
interface ceel_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [ceel_pkg::TIME_W-1:0]     data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== hdl/ceel_hist_mem.sv =====
// History memory of the event log: one write port and one registered read port.
// Depends on ceel_pkg for the entry type.
module ceel_hist_mem #(
	parameter int DEPTH = ceel_pkg::HISTORY_DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output ceel_pkg::hist_entry_t rd_data,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  ceel_pkg::hist_entry_t wr_data
);
	import ceel_pkg::*;

	hist_entry_t mem [DEPTH];

	// Synchronous write and read; read data holds until the next read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

// ===== hdl/ceel_engine.sv =====
// Read-modify-write sequencer of the event log: pointers, counters and the result register.
// Depends on ceel_pkg and the channel interfaces; drives the ports of ceel_hist_mem.
module ceel_engine #(
	parameter int DEPTH = ceel_pkg::HISTORY_DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	ceel_in_if.sink                       in_ch,
	ceel_out_if.source                    out_ch,
	input  logic [ceel_pkg::TIME_W-1:0]   window,
	output logic                          rd_en,
	output logic [AW-1:0]                 rd_addr,
	input  ceel_pkg::hist_entry_t         rd_data,
	output logic                          wr_en,
	output logic [AW-1:0]                 wr_addr,
	output ceel_pkg::hist_entry_t         wr_data
);
	import ceel_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = (CW > RIDX_W) ? CW : RIDX_W;
	localparam int SW = IW + 1;
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);
	localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

	typedef enum logic {ST_IDLE, ST_EXEC} state_t;

	state_t                state_q;
	logic [AW-1:0]         wp_q;
	logic [CW-1:0]         cnt_q;
	logic [TOTAL_W-1:0]    total_q;

	// Request captured at acceptance.
	mode_t                 mode_q;
	hist_tag_t             tag_q;
	logic [TIME_W-1:0]     stamp_q;
	logic                  hit_q;
	logic [AW-1:0]         slot_q;

	// Result register.
	logic                  out_valid_q;
	action_t               action_q;
	logic                  rec_valid_q;
	hist_entry_t           rec_q;
	logic [ENTRIES_W-1:0]  entries_q;
	logic [TOTAL_W-1:0]    total_out_q;

	logic                  accept;
	mode_t                 in_mode;
	logic [AW-1:0]         newest;
	logic [AW-1:0]         oldest;
	logic                  age_ok;
	logic [SW-1:0]         age_sum;
	logic [SW-1:0]         age_slot;
	logic                  hit_d;

	logic                  out_free;
	logic                  finish;
	action_t               act_d;
	logic                  rec_v_d;
	hist_entry_t           rec_d;
	logic                  wr_need;
	logic [AW-1:0]         wr_slot;
	logic [AW-1:0]         wp_n;
	logic [CW-1:0]         cnt_n;
	logic [TOTAL_W-1:0]    total_n;
	logic [TIME_W-1:0]     dt;
	logic                  coalesce;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign in_mode     = mode_t'(in_ch.mode);

	// Slot addressing: newest entry, and the entry of a given age counted from the oldest.
	always_comb begin
		newest   = (wp_q == '0) ? LAST : (wp_q - AW'(1));
		oldest   = (cnt_q == FULL) ? wp_q : '0;
		age_ok   = IW'(in_ch.read_index) < IW'(cnt_q);
		age_sum  = SW'(oldest) + SW'(in_ch.read_index);
		age_slot = (age_sum >= DEPTH_S) ? (age_sum - DEPTH_S) : age_sum;
		hit_d    = (in_mode == MODE_READ) ? age_ok : (cnt_q != '0);
	end

	assign rd_addr = (in_mode == MODE_READ) ? AW'(age_slot) : newest;
	assign rd_en   = accept && hit_d && (in_mode != MODE_CLEAR);

	// Capture the request next to the memory read it starts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_REPORT;
			tag_q   <= '0;
			stamp_q <= '0;
			hit_q   <= 1'b0;
			slot_q  <= '0;
		end else if (accept) begin
			mode_q  <= in_mode;
			tag_q   <= '{source: in_ch.source, code: in_ch.code, severity: in_ch.severity};
			stamp_q <= in_ch.event_time;
			hit_q   <= hit_d;
			slot_q  <= rd_addr;
		end
	end

	// Modify step: decide the action and the new entry from the word read back.
	assign dt       = stamp_q - rd_data.stamp;
	assign coalesce = hit_q && (rd_data.tag == tag_q) && (dt <= window);

	always_comb begin
		act_d   = ACT_IGNORED;
		rec_v_d = hit_q;
		rec_d   = rd_data;
		wr_need = 1'b0;
		wr_slot = wp_q;
		wp_n    = wp_q;
		cnt_n   = cnt_q;
		total_n = total_q;
		unique case (mode_q)
			MODE_CLEAR: begin
				act_d   = ACT_CLEARED;
				rec_v_d = 1'b0;
				wp_n    = '0;
				cnt_n   = '0;
				total_n = '0;
			end
			MODE_READ: begin
				act_d = ACT_READ;
			end
			MODE_REPORT, MODE_UNUSED: begin
				if (mode_q == MODE_REPORT && tag_q.code != '0) begin
					total_n = total_q + TOTAL_W'(1);
					rec_v_d = 1'b1;
					wr_need = 1'b1;
					if (coalesce) begin
						act_d     = ACT_COALESCED;
						wr_slot   = slot_q;
						rec_d.rpt = (rd_data.rpt == REPEAT_MAX) ? rd_data.rpt
							: (rd_data.rpt + RPT_W'(1));
					end else begin
						act_d = ACT_NEW;
						rec_d = '{tag: tag_q, stamp: stamp_q, rpt: RPT_W'(1)};
						wp_n  = (wp_q == LAST) ? '0 : (wp_q + AW'(1));
						cnt_n = (cnt_q == FULL) ? cnt_q : (cnt_q + CW'(1));
					end
				end
			end
		endcase
	end

	assign out_free = !out_valid_q || out_ch.ready;
	assign finish   = (state_q == ST_EXEC) && out_free;

	// Write-back happens in the same cycle the result is registered.
	assign wr_en   = finish && wr_need;
	assign wr_addr = wr_slot;
	assign wr_data = rec_d;

	// Sequencer state, pointers and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			cnt_q       <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			action_q    <= ACT_IGNORED;
			rec_valid_q <= 1'b0;
			rec_q       <= '0;
			entries_q   <= '0;
			total_out_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					// A result word that is taken while idle leaves the register empty.
					if (out_ch.ready) begin
						out_valid_q <= 1'b0;
					end
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					// A stalled result word stays put until the register frees up.
					if (out_free) begin
						state_q     <= ST_IDLE;
						wp_q        <= wp_n;
						cnt_q       <= cnt_n;
						total_q     <= total_n;
						out_valid_q <= 1'b1;
						action_q    <= act_d;
						rec_valid_q <= rec_v_d;
						rec_q       <= rec_v_d ? rec_d : '0;
						entries_q   <= ENTRIES_W'(cnt_n);
						total_out_q <= total_n;
					end
				end
			endcase
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.action         = action_q;
	assign out_ch.rec_valid      = rec_valid_q;
	assign out_ch.rec_source     = rec_q.tag.source;
	assign out_ch.rec_code       = rec_q.tag.code;
	assign out_ch.rec_severity   = rec_q.tag.severity;
	assign out_ch.rec_time       = rec_q.stamp;
	assign out_ch.rec_repeat     = rec_q.rpt;
	assign out_ch.stored_entries = entries_q;
	assign out_ch.total_reports  = total_out_q;
endmodule

// ===== hdl/coalescing_error_event_log.sv =====
// Top level of the coalescing error event log: window register, sequencer and history memory.
// Depends on ceel_pkg, the channel interfaces, ceel_hist_mem and ceel_engine.
//
//   channel  dir  payload
//   in_ch    in   mode, source, code, severity, event_time, read_index
//   out_ch   out  action, rec_* record, stored_entries, total_reports
//   cfg      in   data = coalesce window in ms (reset 100)
//
// Each input word is first read from the history memory, then modified, written
// back and registered as the result word. The input takes a new word only after
// the word in work has finished.
// A full result register stalls the write-back step until the result is taken.
// Reset clears pointers and counters and sets the window to 100 ms; history
// entries are not cleared.
module coalescing_error_event_log #(
	parameter int HISTORY_DEPTH = ceel_pkg::HISTORY_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ceel_in_if.sink     in_ch,
	ceel_out_if.source  out_ch,
	ceel_cfg_if.sink    cfg
);
	import ceel_pkg::*;

	localparam int AW = $clog2(HISTORY_DEPTH);

	logic [TIME_W-1:0] window_q;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	hist_entry_t       rd_data;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	hist_entry_t       wr_data;

	// Coalescing window register; writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg.valid) begin
			window_q <= cfg.data;
		end
	end

	ceel_hist_mem #(
		.DEPTH(HISTORY_DEPTH)
	) u_hist_mem (
		.clk    (clk),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	ceel_engine #(
		.DEPTH(HISTORY_DEPTH)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.window (window_q),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);
endmodule

// ===== hdl/ceel_checker.sv =====
// Port-level checks of the coalescing error event log, bound to the top level.
// Depends on ceel_pkg and coalescing_error_event_log_defines.svh.
`include "coalescing_error_event_log_defines.svh"

module ceel_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [ceel_pkg::ACTION_W-1:0]      action,
	input logic                               rec_valid,
	input logic [ceel_pkg::ENTRIES_W-1:0]     stored_entries,
	input logic [ceel_pkg::TOTAL_W-1:0]       total_reports
);
	import ceel_pkg::*;

	// A result word waits until it is taken.
	`CEEL_ASSERT_CLK(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid, "result word dropped while stalled")

	// Only one word is in work at a time, so an accept closes the input.
	`CEEL_ASSERT_CLK(a_one_in_work, clk, arst_n, in_valid && in_ready |=> !in_ready, "input taken while a word is in work")

	// A clear shows an empty log and a zero total with no record.
	`CEEL_ASSERT_CLK(a_clear_empty, clk, arst_n, out_valid && action == ACT_CLEARED |-> stored_entries == 0 && total_reports == 0 && !rec_valid, "clear result not empty")

	// New and coalesced reports always show the entry they touched.
	`CEEL_ASSERT_CLK(a_write_shows_rec, clk, arst_n, out_valid && (action == ACT_NEW || action == ACT_COALESCED) |-> rec_valid, "written entry not shown")

	// No result word appears right after reset.
	`CEEL_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |=> !out_valid, "result word after reset")
endmodule

bind coalescing_error_event_log ceel_checker u_ceel_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.action        (out_ch.action),
	.rec_valid     (out_ch.rec_valid),
	.stored_entries(out_ch.stored_entries),
	.total_reports (out_ch.total_reports)
);

// ===== bench/tb_top.sv =====
// Self-checking testbench for the coalescing error event log: directed table and random
// event traffic, checked against a shadow log model or, for some directed rows, fixed records.
// Depends on ceel_pkg, the ceel_in_if, ceel_out_if and ceel_cfg_if interfaces, and the RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ceel_pkg::*;

	localparam int DEPTH          = HISTORY_DEPTH_DEF;
	localparam int RANDOM_WORDS   = 950;
	localparam int CALM_AFTER     = 850;

	// One request word as it is put on the input channel.
	typedef struct packed {
		mode_t                 mode;
		logic [SOURCE_W-1:0]   source;
		logic [CODE_W-1:0]     code;
		logic [SEVERITY_W-1:0] severity;
		logic [TIME_W-1:0]     event_time;
		logic [RIDX_W-1:0]     read_index;
	} log_req_t;

	// One record word as it comes out of the result channel.
	typedef struct packed {
		action_t               action;
		logic                  rec_valid;
		logic [SOURCE_W-1:0]   rec_source;
		logic [CODE_W-1:0]     rec_code;
		logic [SEVERITY_W-1:0] rec_severity;
		logic [TIME_W-1:0]     rec_time;
		logic [RPT_W-1:0]      rec_repeat;
		logic [ENTRIES_W-1:0]  stored_entries;
		logic [TOTAL_W-1:0]    total_reports;
	} log_rec_t;

	typedef enum logic {ROW_WORD, ROW_WINDOW} row_kind_t;

	// A directed row; a window row carries the new window in req.event_time.
	typedef struct packed {
		row_kind_t kind;
		log_req_t  req;
		logic      typed;
		log_rec_t  rec;
	} dir_row_t;

	localparam log_rec_t REC_READ_EMPTY =
		'{ACT_READ, 1'b0, 4'h0, 16'h0, 2'd0, 32'h0, 16'h0, 5'd0, 32'd0};
	localparam log_rec_t REC_IGNORED_EMPTY =
		'{ACT_IGNORED, 1'b0, 4'h0, 16'h0, 2'd0, 32'h0, 16'h0, 5'd0, 32'd0};
	localparam log_rec_t REC_CLEARED =
		'{ACT_CLEARED, 1'b0, 4'h0, 16'h0, 2'd0, 32'h0, 16'h0, 5'd0, 32'd0};
	localparam log_rec_t REC_FIRST_MAX =
		'{ACT_NEW, 1'b1, 4'hF, 16'hFFFF, 2'd3, 32'hFFFF_FFF0, 16'd1, 5'd1, 32'd1};
	localparam log_rec_t REC_FIRST_AFTER_CLEAR =
		'{ACT_NEW, 1'b1, 4'h2, 16'h0003, 2'd2, 32'h0000_0007, 16'd1, 5'd1, 32'd1};

	// Directed walk: empty log, extremes, the coalescing boundary across the time wrap,
	// each field of the identity, ignored words, reads in and out of range, window
	// extremes and a clear.
	dir_row_t directed_rows [24] = '{
		'{ROW_WORD, '{MODE_READ, 4'h0, 16'h0000, 2'd0, 32'h0000_0000, 4'h0}, 1'b1, REC_READ_EMPTY},
		'{ROW_WORD, '{MODE_REPORT, 4'h5, 16'h0000, 2'd1, 32'h0000_0010, 4'h3}, 1'b1,
			REC_IGNORED_EMPTY},
		'{ROW_WORD, '{MODE_UNUSED, 4'hA, 16'h1234, 2'd2, 32'h0000_0020, 4'h7}, 1'b1,
			REC_IGNORED_EMPTY},
		'{ROW_WORD, '{MODE_REPORT, 4'hF, 16'hFFFF, 2'd3, 32'hFFFF_FFF0, 4'hF}, 1'b1, REC_FIRST_MAX},
		'{ROW_WORD, '{MODE_REPORT, 4'hF, 16'hFFFF, 2'd3, 32'h0000_0050, 4'h0}, 1'b0, '0},
		'{ROW_WORD, '{MODE_REPORT, 4'hF, 16'hFFFF, 2'd3, 32'h0000_0054, 4'h0}, 1'b0, '0},
		'{ROW_WORD, '{MODE_REPORT, 4'hF, 16'hFFFF, 2'd3, 32'h0000_0055, 4'h0}, 1'b0, '0},
		'{ROW_WORD, '{MODE_REPORT, 4'h0, 16'h0001, 2'd0, 32'h0000_0000, 4'h0}, 1'b0, '0},
		'{ROW_WORD, '{MODE_REPORT, 4'h0, 16'h0001, 2'd1, 32'h0000_0000, 4'h0}, 1'b0, '0},
		'{ROW_WORD, '{MODE_REPORT, 4'h1, 16'h0001, 2'd1, 32'h0000_0000, 4'h0}, 1'b0, '0},
		'{ROW_WORD, '{MODE_REPORT, 4'h1, 16'h0002, 2'd1, 32'h0000_0000, 4'h0}, 1'b0, '0},
		'{ROW_WORD, '{MODE_REPORT, 4'h3, 16'h0000, 2'd3, 32'hFFFF_FFFF, 4'hF}, 1'b0, '0},
		'{ROW_WORD, '{MODE_UNUSED, 4'hA, 16'h0005, 2'd1, 32'h8000_0000, 4'h2}, 1'b0, '0},
		'{ROW_WORD, '{MODE_READ, 4'hF, 16'hFFFF, 2'd3, 32'hFFFF_FFFF, 4'h0}, 1'b0, '0},
		'{ROW_WORD, '{MODE_READ, 4'h0, 16'h0000, 2'd0, 32'h0000_0000, 4'h4}, 1'b0, '0},
		'{ROW_WORD, '{MODE_READ, 4'h0, 16'h0000, 2'd0, 32'h0000_0000, 4'hF}, 1'b0, '0},
		'{ROW_WINDOW, '{MODE_REPORT, 4'h0, 16'h0000, 2'd0, 32'h0000_0000, 4'h0}, 1'b0, '0},
		'{ROW_WORD, '{MODE_REPORT, 4'h1, 16'h0002, 2'd1, 32'h0000_0000, 4'h0}, 1'b0, '0},
		'{ROW_WORD, '{MODE_REPORT, 4'h1, 16'h0002, 2'd1, 32'h0000_0001, 4'h0}, 1'b0, '0},
		'{ROW_WINDOW, '{MODE_REPORT, 4'h0, 16'h0000, 2'd0, 32'hFFFF_FFFF, 4'h0}, 1'b0, '0},
		'{ROW_WORD, '{MODE_REPORT, 4'h1, 16'h0002, 2'd1, 32'h0000_0000, 4'h0}, 1'b0, '0},
		'{ROW_WORD, '{MODE_CLEAR, 4'h9, 16'hABCD, 2'd2, 32'h1234_5678, 4'h5}, 1'b1, REC_CLEARED},
		'{ROW_WORD, '{MODE_READ, 4'h0, 16'h0000, 2'd0, 32'h0000_0000, 4'h0}, 1'b1, REC_READ_EMPTY},
		'{ROW_WORD, '{MODE_REPORT, 4'h2, 16'h0003, 2'd2, 32'h0000_0007, 4'h0}, 1'b1,
			REC_FIRST_AFTER_CLEAR}
	};

	logic clk;
	logic arst_n;

	ceel_in_if  in_ch ();
	ceel_out_if out_ch ();
	ceel_cfg_if cfg ();

	coalescing_error_event_log dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	// Shadow copy of the log contents and settings.
	hist_tag_t         shadow_tag   [DEPTH];
	logic [TIME_W-1:0] shadow_stamp [DEPTH];
	logic [RPT_W-1:0]  shadow_rpt   [DEPTH];
	int                shadow_wp = 0;
	int                shadow_count = 0;
	logic [TOTAL_W-1:0] shadow_total = '0;
	logic [TIME_W-1:0] shadow_window = WINDOW_RESET;

	log_rec_t awaited_records [$];
	int       mismatch_count = 0;
	int       done_words = 0;
	bit       idle_allowed = 1'b1;
	int       idle_level = 0;
	int       out_stall = 0;
	int       tick = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Request word with every field random; the caller fixes what matters.
	function automatic log_req_t rand_req(input mode_t m);
		log_req_t r;
		r.mode       = m;
		r.source     = SOURCE_W'($urandom);
		r.code       = CODE_W'($urandom);
		r.severity   = SEVERITY_W'($urandom);
		r.event_time = $urandom;
		r.read_index = RIDX_W'($urandom);
		return r;
	endfunction

	// Applies one request to the shadow log and returns the record word it produces.
	function automatic log_rec_t next_record(input log_req_t r);
		log_rec_t          o;
		hist_tag_t         tg;
		logic [TIME_W-1:0] age;
		int                newest;
		int                slot;
		logic              show;
		o = '0;
		show = 1'b0;
		slot = 0;
		newest = (shadow_wp == 0) ? DEPTH - 1 : shadow_wp - 1;
		tg = '{r.source, r.code, r.severity};
		case (r.mode)
			MODE_CLEAR: begin
				shadow_wp = 0;
				shadow_count = 0;
				shadow_total = '0;
				o.action = ACT_CLEARED;
			end
			MODE_READ: begin
				o.action = ACT_READ;
				// Age 0 is the oldest; once full, the oldest sits at the write pointer.
				if (r.read_index < shadow_count) begin
					show = 1'b1;
					slot = ((shadow_count < DEPTH ? 0 : shadow_wp) + r.read_index) % DEPTH;
				end
			end
			default: begin
				if (r.mode == MODE_UNUSED || r.code == '0) begin
					o.action = ACT_IGNORED;
					show = (shadow_count > 0);
					slot = newest;
				end else begin
					shadow_total++;
					age = r.event_time - shadow_stamp[newest];
					if (shadow_count > 0 && shadow_tag[newest] == tg && age <= shadow_window) begin
						// Same identity inside the window folds into the newest entry.
						if (shadow_rpt[newest] != REPEAT_MAX)
							shadow_rpt[newest]++;
						o.action = ACT_COALESCED;
						show = 1'b1;
						slot = newest;
					end else begin
						slot = shadow_wp;
						shadow_tag[slot] = tg;
						shadow_stamp[slot] = r.event_time;
						shadow_rpt[slot] = 16'd1;
						shadow_wp = (slot + 1) % DEPTH;
						if (shadow_count < DEPTH)
							shadow_count++;
						o.action = ACT_NEW;
						show = 1'b1;
					end
				end
			end
		endcase
		if (show) begin
			o.rec_valid    = 1'b1;
			o.rec_source   = shadow_tag[slot].source;
			o.rec_code     = shadow_tag[slot].code;
			o.rec_severity = shadow_tag[slot].severity;
			o.rec_time     = shadow_stamp[slot];
			o.rec_repeat   = shadow_rpt[slot];
		end
		o.stored_entries = ENTRIES_W'(shadow_count);
		o.total_reports  = shadow_total;
		return o;
	endfunction

	// Offers one word, optionally after a short gap, and records its expected result.
	task automatic send_word(input log_req_t r, input logic typed, input log_rec_t typed_rec);
		int       gap;
		log_rec_t predicted;
		gap = 0;
		if (idle_allowed && idle_level != 0 &&
			$urandom_range(0, (idle_level == 1) ? 7 : 2) == 0)
			gap = $urandom_range(1, 3);
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.mode       <= r.mode;
		in_ch.source     <= r.source;
		in_ch.code       <= r.code;
		in_ch.severity   <= r.severity;
		in_ch.event_time <= r.event_time;
		in_ch.read_index <= r.read_index;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		predicted = next_record(r);
		awaited_records.push_back(typed ? typed_rec : predicted);
		done_words++;
	endtask

	// Holds the input channel quiet until every awaited record has come back.
	task automatic settle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (awaited_records.size() != 0)
			@(posedge clk);
	endtask

	// Changes the coalescing window while the log is idle.
	task automatic write_window(input logic [TIME_W-1:0] v);
		settle();
		cfg.valid <= 1'b1;
		cfg.data  <= v;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		cfg.valid <= 1'b0;
		shadow_window = v;
	endtask

	task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
		if (e !== a) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
		end
	endtask

	task automatic check_record(input log_rec_t e);
		check_field("action", 32'(e.action), 32'(out_ch.action));
		check_field("rec_valid", 32'(e.rec_valid), 32'(out_ch.rec_valid));
		check_field("rec_source", 32'(e.rec_source), 32'(out_ch.rec_source));
		check_field("rec_code", 32'(e.rec_code), 32'(out_ch.rec_code));
		check_field("rec_severity", 32'(e.rec_severity), 32'(out_ch.rec_severity));
		check_field("rec_time", e.rec_time, out_ch.rec_time);
		check_field("rec_repeat", 32'(e.rec_repeat), 32'(out_ch.rec_repeat));
		check_field("stored_entries", 32'(e.stored_entries), 32'(out_ch.stored_entries));
		check_field("total_reports", e.total_reports, out_ch.total_reports);
	endtask

	// Result side: compare each accepted word with the oldest expectation, then decide
	// whether to stall the next cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			idle_level = 0;
			out_stall = 0;
		end else begin
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
				if (awaited_records.size() == 0) begin
					mismatch_count++;
					$display("%0t: record word with none awaited, expected none, actual %0h",
						$time, out_ch.action);
				end else begin
					check_record(awaited_records.pop_front());
				end
			end
			// The idling intensity is picked anew on the tick counter, including calm stretches.
			tick++;
			if (tick % 40 == 0)
				idle_level = $urandom_range(0, 2);
			if (out_stall != 0) begin
				out_stall--;
				out_ch.ready <= 1'b0;
			end else if (idle_allowed && idle_level != 0 &&
				$urandom_range(0, (idle_level == 1) ? 7 : 2) == 0) begin
				out_stall = $urandom_range(0, 2);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		log_req_t          r;
		hist_tag_t         pool [4];
		hist_tag_t         tg;
		logic [TIME_W-1:0] now;
		int                pick;
		int                len;
		arst_n           <= 1'b0;
		in_ch.valid      <= 1'b0;
		in_ch.mode       <= MODE_REPORT;
		in_ch.source     <= '0;
		in_ch.code       <= '0;
		in_ch.severity   <= '0;
		in_ch.event_time <= '0;
		in_ch.read_index <= '0;
		cfg.valid        <= 1'b0;
		cfg.data         <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[n]) begin
			if (directed_rows[n].kind == ROW_WINDOW)
				write_window(directed_rows[n].req.event_time);
			else
				send_word(directed_rows[n].req, directed_rows[n].typed, directed_rows[n].rec);
		end

		// A few recurring identities make coalescing and re-entry likely.
		foreach (pool[p]) begin
			pool[p].source   = SOURCE_W'($urandom);
			pool[p].code     = CODE_W'($urandom_range(1, 16'hFFFF));
			pool[p].severity = SEVERITY_W'($urandom);
		end

		done_words = 0;
		while (done_words < RANDOM_WORDS) begin
			if (done_words >= CALM_AFTER)
				idle_allowed = 1'b0;
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				// Burst of one identity with time steps around the window edge.
				if ($urandom_range(0, 9) < 7) begin
					tg = pool[$urandom_range(0, 3)];
				end else begin
					tg.source   = SOURCE_W'($urandom);
					tg.code     = CODE_W'($urandom_range(1, 16'hFFFF));
					tg.severity = SEVERITY_W'($urandom);
				end
				len = $urandom_range(1, 6);
				now = $urandom;
				for (int k = 0; k < len; k++) begin
					if (k != 0) begin
						case ($urandom_range(0, 4))
							0: now = now;
							1: now = now + $urandom_range(0, shadow_window);
							2: now = now + shadow_window;
							3: now = now + shadow_window + 1;
							default: now = now + $urandom;
						endcase
					end
					r = rand_req(MODE_REPORT);
					r.source = tg.source;
					r.code = tg.code;
					r.severity = tg.severity;
					r.event_time = now;
					send_word(r, 1'b0, '0);
				end
			end else if (pick < 70) begin
				send_word(rand_req(MODE_READ), 1'b0, '0);
			end else if (pick < 82) begin
				send_word(rand_req(MODE_REPORT), 1'b0, '0);
			end else if (pick < 87) begin
				r = rand_req(MODE_REPORT);
				r.code = '0;
				send_word(r, 1'b0, '0);
			end else if (pick < 91) begin
				send_word(rand_req(MODE_UNUSED), 1'b0, '0);
			end else if (pick < 94) begin
				send_word(rand_req(MODE_CLEAR), 1'b0, '0);
			end else if (pick < 97) begin
				case ($urandom_range(0, 4))
					0: write_window('0);
					1: write_window('1);
					2: write_window(WINDOW_RESET);
					3: write_window($urandom_range(1, 1000));
					default: write_window($urandom);
				endcase
			end else begin
				// Let the log run completely dry before the next word.
				settle();
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && awaited_records.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
